[hw/rtl/dftr_pkg.sv]
// Shared types, codes and defaults for the deferred-free token ring.
package dftr_pkg;

  localparam int MAX_THREADS_DEF = 8;
  localparam int RING_LOG2_DEF   = 6;

  localparam logic OP_DEFER  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_NULL = 2'd3;

  localparam logic CFG_THREAD_COUNT   = 1'b0;
  localparam logic CFG_POST_THRESHOLD = 1'b1;

  typedef struct packed {
    logic        op;
    logic [2:0]  thread;
    logic [63:0] ptr;
    logic [1:0]  pre_status;
  } cmd_t;

endpackage

[hw/rtl/deferred_free_token_ring_core.sv]
// Top level of the deferred-free token ring: configuration, front end and back end.
// A defer result is loaded after the ring write and the post check, a flagged item's from
// the execute state. An update compares each other thread's token pair, reads its own token,
// then outputs its released pointers one at a time, each read first, as out_ready allows.
// Items run one at a time behind a two-entry queue. Synchronous active-low reset clears the
// token stores through valid bits, ring positions and configuration, not the pointer store.
module deferred_free_token_ring_core #(
  parameter int MAX_THREADS = dftr_pkg::MAX_THREADS_DEF,
  parameter int RING_LOG2   = dftr_pkg::RING_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // opcode[0], thread[3:1], pointer[67:4], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status[1:0], freed_valid[2], freed_address[66:3], zeros
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [5:0]  cfg_data
);

  localparam int NW = $clog2(MAX_THREADS + 1);

  logic [3:0] thread_count_r;
  logic [5:0] post_threshold_r;
  logic [NW-1:0] n_eff;
  logic q_valid, q_pop;
  dftr_pkg::cmd_t q_cmd;
  logic [1:0] st;
  logic fv;
  logic [63:0] addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thread_count_r <= 4'd1;
      post_threshold_r <= 6'd10;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dftr_pkg::CFG_THREAD_COUNT:   thread_count_r <= cfg_data[3:0];
        dftr_pkg::CFG_POST_THRESHOLD: post_threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (thread_count_r == 4'd0) begin
      n_eff = NW'(1);
    end else if (int'(thread_count_r) > MAX_THREADS) begin
      n_eff = NW'(MAX_THREADS);
    end else begin
      n_eff = NW'(thread_count_r);
    end
  end

  dftr_front #(.NW(NW)) u_front (
    .clk(clk), .rst_n(rst_n), .n_eff(n_eff),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[0]), .thread(in_tdata[3:1]), .ptr(in_tdata[67:4]),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  dftr_back #(.MAX_THREADS(MAX_THREADS), .RING_LOG2(RING_LOG2), .NW(NW)) u_back (
    .clk(clk), .rst_n(rst_n), .n_eff(n_eff), .post_threshold(post_threshold_r),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(st), .out_freed_valid(fv), .out_freed_address(addr), .out_last(out_tlast)
  );

  assign out_tdata = {5'd0, addr, fv, st};

endmodule

[hw/rtl/dftr_front.sv]
// Front end: accepts items, flags bad threads and null defer pointers, two-entry queue.
module dftr_front #(
  parameter int NW = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [NW-1:0]    n_eff,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic [2:0]       thread,
  input  logic [63:0]      ptr,
  output logic             q_valid,
  output dftr_pkg::cmd_t   q_cmd,
  input  logic             q_pop
);

  dftr_pkg::cmd_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  dftr_pkg::cmd_t c;
  logic push;

  always_comb begin
    c.op = op;
    c.thread = thread;
    c.ptr = ptr;
    if (32'(thread) >= 32'(n_eff)) begin
      c.pre_status = dftr_pkg::ST_BAD;
    end else if (op == dftr_pkg::OP_DEFER && ptr == 64'd0) begin
      c.pre_status = dftr_pkg::ST_NULL;
    end else begin
      c.pre_status = dftr_pkg::ST_OK;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

[hw/rtl/dftr_back.sv]
// Back end: executes defers and updates against the token and pointer stores.
module dftr_back #(
  parameter int MAX_THREADS = dftr_pkg::MAX_THREADS_DEF,
  parameter int RING_LOG2   = dftr_pkg::RING_LOG2_DEF,
  parameter int NW          = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [NW-1:0]  n_eff,
  input  logic [5:0]     post_threshold,
  input  logic           q_valid,
  input  dftr_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output logic           out_freed_valid,
  output logic [63:0]    out_freed_address,
  output logic           out_last
);

  localparam int TW   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int AW   = $clog2(MAX_THREADS * MAX_THREADS);
  localparam int TD   = MAX_THREADS * MAX_THREADS;
  localparam int PD   = MAX_THREADS << RING_LOG2;
  localparam int PW   = TW + RING_LOG2;
  localparam int KW   = RING_LOG2 + 1;
  localparam logic [KW-1:0] KMAX = KW'((1 << RING_LOG2) - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DEF_CHK, S_UPD_RD, S_UPD_CMP, S_REL_OWN, S_REL_CHK, S_REL_DAT
  } state_t;

  state_t state_r;
  dftr_pkg::cmd_t cmd_r;
  logic [NW-1:0] i_r;
  logic [KW-1:0] k_r;
  logic [31:0] own_r;

  logic [31:0] heads_r [MAX_THREADS];
  logic [31:0] tails_r [MAX_THREADS];

  logic [31:0] tok_mem [TD];
  logic [31:0] pst_mem [TD];
  logic [TD-1:0] tok_vld_r, pst_vld_r;
  logic [31:0] tok_q_r, pst_q_r;
  logic tok_qv_r, pst_qv_r;
  logic [63:0] pend_mem [PD];
  logic [63:0] pend_q_r;

  logic out_valid_r, out_fv_r, out_last_r;
  logic [1:0] out_st_r;
  logic [63:0] out_addr_r;

  logic [TW-1:0] t, nxt;
  logic [NW-1:0] t_n;
  logic [31:0] head, tail, head1, tail1, tok_rd, pst_rd;
  logic full, slot_free, rel_cond, last_nxt;
  logic exec_err, out_load;
  logic [KW-1:0] k1;

  logic          tok_re, pst_re, tok_we, pst_we, pend_re, pend_we;
  logic [AW-1:0] tok_ra, pst_ra, tok_wa, pst_wa;
  logic [31:0]   tok_wd, pst_wd;
  logic [PW-1:0] pend_a;

  function automatic logic [AW-1:0] taddr(input logic [TW-1:0] row, input logic [TW-1:0] col);
    taddr = AW'(int'(row) * MAX_THREADS + int'(col));
  endfunction

  assign t     = TW'(cmd_r.thread);
  assign t_n   = NW'(cmd_r.thread);
  assign nxt   = (NW'(t_n + NW'(1)) == n_eff) ? '0 : TW'(t_n + NW'(1));
  assign head  = heads_r[t];
  assign tail  = tails_r[t];
  assign head1 = head + 32'd1;
  assign tail1 = tail + 32'd1;
  assign full  = (head1[RING_LOG2-1:0] == tail[RING_LOG2-1:0]);
  assign tok_rd = tok_qv_r ? tok_q_r : 32'd0;
  assign pst_rd = pst_qv_r ? pst_q_r : 32'd0;
  assign slot_free = !out_valid_r || out_ready;
  assign k1 = k_r + KW'(1);
  assign rel_cond = (tail != own_r) && (tail != head) && (k_r < KMAX);
  assign last_nxt = !((tail1 != own_r) && (tail1 != head) && (k1 < KMAX));
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign exec_err = (cmd_r.pre_status != dftr_pkg::ST_OK) ||
                    (cmd_r.op == dftr_pkg::OP_DEFER && full);

  // A result is loaded into the output register in this cycle.
  assign out_load = slot_free && (((state_r == S_EXEC) && exec_err) ||
                                  (state_r == S_DEF_CHK) ||
                                  ((state_r == S_REL_CHK) && !rel_cond) ||
                                  (state_r == S_REL_DAT));

  // Store access control per state.
  always_comb begin
    tok_re = 1'b0; pst_re = 1'b0; tok_we = 1'b0; pst_we = 1'b0;
    pend_re = 1'b0; pend_we = 1'b0;
    tok_ra = taddr(t, TW'(i_r)); pst_ra = taddr(t, TW'(i_r));
    tok_wa = taddr(nxt, TW'(i_r)); pst_wa = taddr(t, TW'(i_r));
    tok_wd = tok_rd; pst_wd = tok_rd;
    pend_a = {t, tail[RING_LOG2-1:0]};
    unique case (state_r)
      S_EXEC: begin
        if (cmd_r.pre_status == dftr_pkg::ST_OK && cmd_r.op == dftr_pkg::OP_DEFER && !full) begin
          pend_we = 1'b1;
          pend_a = {t, head[RING_LOG2-1:0]};
          pst_re = 1'b1;
          pst_ra = taddr(t, t);
        end
      end
      S_DEF_CHK: begin
        if (slot_free && (head - pst_rd) >= {26'd0, post_threshold}) begin
          tok_we = 1'b1; pst_we = 1'b1;
          tok_wa = taddr(nxt, t); pst_wa = taddr(t, t);
          tok_wd = head; pst_wd = head;
        end
      end
      S_UPD_RD: begin
        if (i_r == n_eff) begin
          tok_re = 1'b1;
          tok_ra = taddr(t, t);
        end else if (i_r != t_n) begin
          tok_re = 1'b1; pst_re = 1'b1;
        end
      end
      S_UPD_CMP: begin
        if (tok_rd != pst_rd) begin
          tok_we = 1'b1; pst_we = 1'b1;
        end
      end
      S_REL_CHK: pend_re = rel_cond;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok_we) tok_mem[tok_wa] <= tok_wd;
    if (pst_we) pst_mem[pst_wa] <= pst_wd;
    if (tok_re) tok_q_r <= tok_mem[tok_ra];
    if (pst_re) pst_q_r <= pst_mem[pst_ra];
    if (pend_we) pend_mem[pend_a] <= cmd_r.ptr;
    if (pend_re) pend_q_r <= pend_mem[pend_a];
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= '0;
      pst_vld_r <= '0;
      tok_qv_r <= 1'b0;
      pst_qv_r <= 1'b0;
    end else begin
      if (tok_we) tok_vld_r[tok_wa] <= 1'b1;
      if (pst_we) pst_vld_r[pst_wa] <= 1'b1;
      if (tok_re) tok_qv_r <= tok_vld_r[tok_ra];
      if (pst_re) pst_qv_r <= pst_vld_r[pst_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_THREADS; j++) begin
        heads_r[j] <= 32'd0;
        tails_r[j] <= 32'd0;
      end
      i_r <= '0;
      k_r <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_err) begin
            if (slot_free) begin
              out_st_r <= (cmd_r.pre_status != dftr_pkg::ST_OK) ? cmd_r.pre_status
                                                               : dftr_pkg::ST_FULL;
              out_fv_r <= 1'b0;
              out_addr_r <= 64'd0;
              out_last_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else if (cmd_r.op == dftr_pkg::OP_DEFER) begin
            heads_r[t] <= head1;
            state_r <= S_DEF_CHK;
          end else begin
            i_r <= '0;
            state_r <= S_UPD_RD;
          end
        end
        S_DEF_CHK: begin
          if (slot_free) begin
            out_st_r <= dftr_pkg::ST_OK;
            out_fv_r <= 1'b0;
            out_addr_r <= 64'd0;
            out_last_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_UPD_RD: begin
          if (i_r == n_eff) begin
            state_r <= S_REL_OWN;
          end else if (i_r == t_n) begin
            i_r <= i_r + NW'(1);
          end else begin
            state_r <= S_UPD_CMP;
          end
        end
        S_UPD_CMP: begin
          i_r <= i_r + NW'(1);
          state_r <= S_UPD_RD;
        end
        S_REL_OWN: begin
          own_r <= tok_rd;
          k_r <= '0;
          state_r <= S_REL_CHK;
        end
        S_REL_CHK: begin
          if (rel_cond) begin
            state_r <= S_REL_DAT;
          end else if (slot_free) begin
            // Nothing to release: a single empty result.
            out_st_r <= dftr_pkg::ST_OK;
            out_fv_r <= 1'b0;
            out_addr_r <= 64'd0;
            out_last_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_REL_DAT: begin
          if (slot_free) begin
            out_st_r <= dftr_pkg::ST_OK;
            out_fv_r <= 1'b1;
            out_addr_r <= pend_q_r;
            out_last_r <= last_nxt;
            tails_r[t] <= tail1;
            k_r <= k1;
            state_r <= last_nxt ? S_IDLE : S_REL_CHK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_freed_valid   = out_fv_r;
  assign out_freed_address = out_addr_r;
  assign out_last          = out_last_r;

endmodule

[dv/tb_deferred_free_token_ring_core.sv]
// Self-checking testbench for the deferred-free token ring core.
module tb_deferred_free_token_ring_core;
  timeunit 1ns;
  timeprecision 1ps;

  class free_ring_scoreboard;
    typedef struct {
      logic [1:0]  status;
      bit          freed_valid;
      bit [63:0]   freed_address;
      bit          last;
    } release_t;

    release_t    release_q[$];
    int          errors;
    bit [3:0]    thread_cnt;
    bit [5:0]    threshold;
    bit [31:0]   tokens[64];
    bit [31:0]   posted[64];
    bit [31:0]   heads[8];
    bit [31:0]   tails[8];
    bit [63:0]   pending[512];

    function new();
      thread_cnt = 4'd1;
      threshold  = 6'd10;
      errors     = 0;
      foreach (tokens[i]) begin
        tokens[i] = '0;
        posted[i] = '0;
      end
      foreach (heads[i]) begin
        heads[i] = '0;
        tails[i] = '0;
      end
    endfunction

    function int live_threads();
      if (thread_cnt == 0) return 1;
      if (thread_cnt > 8) return 8;
      return thread_cnt;
    endfunction

    function void write_reg(logic idx, bit [5:0] value);
      if (idx == dftr_pkg::CFG_THREAD_COUNT) thread_cnt = value[3:0];
      else threshold = value;
    endfunction

    function void push(logic [1:0] st, bit fv, bit [63:0] addr, bit last);
      release_t r;
      r.status = st;
      r.freed_valid = fv;
      r.freed_address = addr;
      r.last = last;
      release_q.push_back(r);
    endfunction

    // Works out every result that one accepted item causes.
    function void note_input(logic op, bit [2:0] t, bit [63:0] ptr);
      int n;
      int nxt;
      int k;
      bit [31:0] head;
      bit [31:0] tail;
      bit [31:0] own;
      n = live_threads();
      if (t >= n) begin
        push(dftr_pkg::ST_BAD, 0, '0, 1);
        return;
      end
      nxt = (t + 1) % n;
      if (op == dftr_pkg::OP_DEFER) begin
        head = heads[t];
        if (ptr == 0) begin
          push(dftr_pkg::ST_NULL, 0, '0, 1);
          return;
        end
        if (((head + 1) & 32'd63) == (tails[t] & 32'd63)) begin
          push(dftr_pkg::ST_FULL, 0, '0, 1);
          return;
        end
        pending[t * 64 + (head & 32'd63)] = ptr;
        head = head + 1;
        heads[t] = head;
        if (head - posted[t * 8 + t] >= {26'd0, threshold}) begin
          tokens[nxt * 8 + t] = head;
          posted[t * 8 + t] = head;
        end
        push(dftr_pkg::ST_OK, 0, '0, 1);
        return;
      end
      for (int i = 0; i < n; i++) begin
        if (i != t && tokens[t * 8 + i] != posted[t * 8 + i]) begin
          posted[t * 8 + i] = tokens[t * 8 + i];
          tokens[nxt * 8 + i] = tokens[t * 8 + i];
        end
      end
      own = tokens[t * 8 + t];
      tail = tails[t];
      head = heads[t];
      k = 0;
      while (tail != own && tail != head && k < 63) begin
        push(dftr_pkg::ST_OK, 1, pending[t * 64 + (tail & 32'd63)], 0);
        k++;
        tail = tail + 1;
      end
      tails[t] = tail;
      if (k == 0) push(dftr_pkg::ST_OK, 0, '0, 1);
      else release_q[release_q.size() - 1].last = 1;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(logic [71:0] data, logic last);
      release_t e;
      if (release_q.size() == 0) begin
        report($sformatf("unexpected result data=%h last=%b", data, last));
        return;
      end
      e = release_q.pop_front();
      if (data[1:0] !== e.status)
        report($sformatf("status exp %0d got %0d", e.status, data[1:0]));
      if (data[2] !== e.freed_valid)
        report($sformatf("freed_valid exp %0d got %0d", e.freed_valid, data[2]));
      if (data[66:3] !== e.freed_address)
        report($sformatf("freed_address exp %h got %h", e.freed_address, data[66:3]));
      if (last !== e.last)
        report($sformatf("last exp %0d got %0d", e.last, last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_idx;
  logic [5:0]  cfg_data;

  free_ring_scoreboard sb = new();
  bit no_idle;
  bit hold_request;

  deferred_free_token_ring_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Result side: random stalls per item, one long hold-off on request.
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = no_idle ? 0 : $urandom_range(0, 11);
      if (hold_request) begin
        hold_request = 0;
        n = 300;
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_item(logic op, bit [2:0] t, bit [63:0] ptr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, ptr, t, op};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, t, ptr);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.release_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, bit [5:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic random_items(int count);
    logic      op;
    bit [2:0]  t;
    bit [63:0] ptr;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < 60) ? dftr_pkg::OP_DEFER : dftr_pkg::OP_UPDATE;
      if ($urandom_range(0, 99) < 85) t = 3'($urandom_range(0, sb.live_threads() - 1));
      else t = 3'($urandom_range(0, 7));
      ptr = ($urandom_range(0, 19) == 0) ? 64'd0 : {$urandom, $urandom};
      send_item(op, t, ptr);
    end
  endtask

  task automatic phase(bit [5:0] tc, bit [5:0] thr, int count);
    settle();
    write_reg(dftr_pkg::CFG_THREAD_COUNT, tc);
    write_reg(dftr_pkg::CFG_POST_THRESHOLD, thr);
    random_items(count);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_idx    = dftr_pkg::CFG_THREAD_COUNT;
    cfg_data   = '0;
    no_idle    = 0;
    hold_request = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: one thread, threshold ten.
    send_item(dftr_pkg::OP_DEFER, 3'd1, 64'h1);
    send_item(dftr_pkg::OP_UPDATE, 3'd7, 64'h0);
    send_item(dftr_pkg::OP_DEFER, 3'd0, 64'h0);
    send_item(dftr_pkg::OP_UPDATE, 3'd0, 64'h0);
    send_item(dftr_pkg::OP_DEFER, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(dftr_pkg::OP_DEFER, 3'd0, 64'h1);
    send_item(dftr_pkg::OP_DEFER, 3'd0, 64'h8000_0000_0000_0000);
    send_item(dftr_pkg::OP_DEFER, 3'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(dftr_pkg::OP_DEFER, 3'd0, 64'h5555_5555_5555_5555);
    for (int i = 0; i < 5; i++) send_item(dftr_pkg::OP_DEFER, 3'd0, 64'h100 + i);
    send_item(dftr_pkg::OP_UPDATE, 3'd0, 64'h0);

    // Fill one ring until it overflows; at this threshold the only post comes with the last item that fits.
    settle();
    write_reg(dftr_pkg::CFG_THREAD_COUNT, 6'd2);
    write_reg(dftr_pkg::CFG_POST_THRESHOLD, 6'd63);
    for (int i = 0; i < 64; i++) begin
      send_item(dftr_pkg::OP_DEFER, 3'd1, {$urandom, $urandom} | 64'h1);
    end
    send_item(dftr_pkg::OP_UPDATE, 3'd1, 64'h0);
    send_item(dftr_pkg::OP_UPDATE, 3'd0, 64'h0);

    phase(6'd8, 6'd1, 6);
    settle();
    no_idle = 1;
    random_items(4);
    no_idle = 0;
    // Long hold-off on the result side while items keep coming.
    hold_request = 1;
    random_items(8);
    phase(6'd3, 6'd5, 4);
    phase(6'd15, 6'd63, 3);
    phase(6'd0, 6'd0, 3);
    phase(6'd2, 6'd2, 3);

    settle();
    repeat (60) @(negedge clk);
    if (sb.errors == 0 && sb.release_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
